### rtl/hhbl_pkg.sv
// ----------------------------------------------------------------------------
// HTTP header byte lexer package
// Shared types, codes and helper functions for the header lexer.
// ----------------------------------------------------------------------------
package hhbl_pkg;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   typedef enum logic [2:0] {
      KIND_NAME_CHAR    = 3'd0,
      KIND_NAME_END     = 3'd1,
      KIND_CONTENT_CHAR = 3'd2,
      KIND_LWS          = 3'd3,
      KIND_VALUE_END    = 3'd4,
      KIND_HEADER_END   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_START      = 3'd0,
      ST_LINE_START = 3'd1,
      ST_LINE_CR    = 3'd2,
      ST_NAME       = 3'd3,
      ST_VALUE      = 3'd4,
      ST_VALUE_WS   = 3'd5,
      ST_INLINE_CR  = 3'd6,
      ST_BODY       = 3'd7
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
      logic       last;
   } token_type;

   // Tokens produced by one accepted request byte.
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } lex_out_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic token_type make_tok(input kind_type kind, input logic [7:0] chr,
                                          input logic last);
      token_type t;
      t.kind = kind;
      t.chr  = chr;
      t.last = last;
      return t;
   endfunction

endpackage

### rtl/hhbl_lexer.sv
// ----------------------------------------------------------------------------
// HTTP header lexer state machine
// Holds the lexer state and turns each accepted byte into up to two tokens.
// ----------------------------------------------------------------------------
module hhbl_lexer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   output hhbl_pkg::lex_out_type lex_out
);

   hhbl_pkg::state_type   state_ff;
   hhbl_pkg::state_type   state_in;
   hhbl_pkg::lex_out_type lex;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hhbl_pkg::ST_START;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      lex      = '0;
      case (state_ff)
         hhbl_pkg::ST_START: begin
            if (in_byte == hhbl_pkg::CHAR_CR) begin
               state_in = hhbl_pkg::ST_LINE_CR;
            end else begin
               state_in  = hhbl_pkg::ST_NAME;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_NAME_CHAR, in_byte, 1'b1);
            end
         end
         hhbl_pkg::ST_LINE_START: begin
            if (in_byte == hhbl_pkg::CHAR_CR) begin
               state_in  = hhbl_pkg::ST_LINE_CR;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_VALUE_END, 8'd0, 1'b1);
            end else if (hhbl_pkg::is_ws(in_byte)) begin
               state_in  = hhbl_pkg::ST_VALUE_WS;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_LWS, 8'd0, 1'b1);
            end else begin
               state_in  = hhbl_pkg::ST_NAME;
               lex.count = 2'd2;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_VALUE_END, 8'd0, 1'b0);
               lex.tok1  = hhbl_pkg::make_tok(hhbl_pkg::KIND_NAME_CHAR, in_byte, 1'b1);
            end
         end
         hhbl_pkg::ST_LINE_CR: begin
            if (in_byte == hhbl_pkg::CHAR_LF) begin
               state_in  = hhbl_pkg::ST_BODY;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_HEADER_END, 8'd0, 1'b1);
            end else if (hhbl_pkg::is_ws(in_byte)) begin
               state_in  = hhbl_pkg::ST_VALUE_WS;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_LWS, 8'd0, 1'b1);
            end else begin
               state_in  = hhbl_pkg::ST_NAME;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_NAME_CHAR, in_byte, 1'b1);
            end
         end
         hhbl_pkg::ST_NAME: begin
            if (in_byte == hhbl_pkg::CHAR_CR) begin
               state_in = hhbl_pkg::ST_INLINE_CR;
            end else if (in_byte == hhbl_pkg::CHAR_COLON) begin
               state_in  = hhbl_pkg::ST_VALUE;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_NAME_END, 8'd0, 1'b1);
            end else begin
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_NAME_CHAR, in_byte, 1'b1);
            end
         end
         hhbl_pkg::ST_VALUE: begin
            if (in_byte == hhbl_pkg::CHAR_CR) begin
               state_in = hhbl_pkg::ST_INLINE_CR;
            end else if (hhbl_pkg::is_ws(in_byte)) begin
               state_in  = hhbl_pkg::ST_VALUE_WS;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_LWS, 8'd0, 1'b1);
            end else begin
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_CONTENT_CHAR, in_byte, 1'b1);
            end
         end
         hhbl_pkg::ST_VALUE_WS: begin
            if (in_byte == hhbl_pkg::CHAR_CR) begin
               state_in = hhbl_pkg::ST_INLINE_CR;
            end else if (!hhbl_pkg::is_ws(in_byte)) begin
               state_in  = hhbl_pkg::ST_VALUE;
               lex.count = 2'd1;
               lex.tok0  = hhbl_pkg::make_tok(hhbl_pkg::KIND_CONTENT_CHAR, in_byte, 1'b1);
            end
         end
         hhbl_pkg::ST_INLINE_CR: begin
            if (in_byte == hhbl_pkg::CHAR_LF) begin
               state_in = hhbl_pkg::ST_LINE_START;
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
      if (!accept) begin
         lex.count = 2'd0;
      end
   end

   assign lex_out = lex;

endmodule

### rtl/hhbl_out_buffer.sv
// ----------------------------------------------------------------------------
// HTTP header lexer token buffer
// Three-slot shifting queue that takes up to two tokens per cycle and
// presents one token per cycle on the result channel while it is ready.
// ----------------------------------------------------------------------------
module hhbl_out_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  hhbl_pkg::lex_out_type lex_in,
   output logic                  has_room,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output hhbl_pkg::token_type   rsp_token
);

   hhbl_pkg::token_type slot_ff [3];
   hhbl_pkg::token_type slot_in [3];
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic [1:0]          base;
   logic [1:0]          base_next;
   logic                pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign base       = count_ff - {1'b0, pop};
   assign base_next  = base + 2'd1;
   assign has_room   = (base <= 2'd1);
   assign rsp_token  = slot_ff[0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pop && (i < 2)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((lex_in.count != 2'd0) && (base == 2'(i))) begin
            slot_in[i] = lex_in.tok0;
         end
         if ((lex_in.count == 2'd2) && (base_next == 2'(i))) begin
            slot_in[i] = lex_in.tok1;
         end
      end
      count_in = base + lex_in.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

### rtl/http_header_byte_lexer.sv
// Tokens are registered in the token buffer before they reach the result channel.
// Throughput: one byte per cycle while the token buffer has room; a byte that
// yields two tokens (field-value end followed by a name character) occupies the single-token output for each in turn.
// Reset: synchronous, active high; the lexer returns to the start state and the
// token buffer empties.
// ----------------------------------------------------------------------------
// HTTP header byte lexer
// Byte-serial lexer for an HTTP message header with a stream request input
// and a stream token output.
// ----------------------------------------------------------------------------
module http_header_byte_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_char
   output logic [2:0] rsp_tuser,   // [2:0] token_kind
   output logic       rsp_tlast
);

   hhbl_pkg::lex_out_type lex_out;
   hhbl_pkg::token_type   rsp_token;
   logic                  has_room;
   logic                  accept;

   assign req_tready = has_room;
   assign accept     = req_tvalid && has_room;

   hhbl_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .lex_out (lex_out)
   );

   hhbl_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .lex_in     (lex_out),
      .has_room   (has_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_token  (rsp_token)
   );

   assign rsp_tdata = rsp_token.chr;
   assign rsp_tuser = rsp_token.kind;
   assign rsp_tlast = rsp_token.last;

endmodule
